// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define DRFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also holds during reset
`define DRFD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/drfd_pkg.sv
// package with types, constants and codes of the delta run-length frame decoder
`default_nettype none

package drfd_pkg;

    // frame store geometry
    localparam int MAX_FRAME_BYTES = 8192;
    localparam int STORE_AW        = $clog2(MAX_FRAME_BYTES);

    // field widths
    localparam int POS_W    = 14;
    localparam int LIT_W    = 6;
    localparam int SPOS_W   = 24;
    localparam int FCNT_W   = 16;
    localparam int RADDR_W  = 13;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 24;

    // saturation limits
    localparam logic [POS_W-1:0]  POS_MAX    = 14'h3FFF;
    localparam logic [SPOS_W-1:0] STREAM_MAX = 24'hFFFFFF;
    localparam logic [FCNT_W-1:0] COUNT_MAX  = 16'hFFFF;

    // byte codes
    localparam logic [7:0] END_BYTE  = 8'h00;
    localparam logic [7:0] FILL_ZERO = 8'h00;
    localparam logic [7:0] FILL_ONE  = 8'hFF;

    // command types in bits 7..6
    localparam logic [1:0] TYPE_SKIP  = 2'b00;
    localparam logic [1:0] TYPE_LIT   = 2'b01;
    localparam logic [1:0] TYPE_FILL0 = 2'b10;
    localparam logic [1:0] TYPE_FILL1 = 2'b11;

    // item command codes
    localparam logic CMD_STREAM = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_FRAME_BYTES  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_FRAME_TOTAL  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_STREAM_BYTES = 2'd2;

    typedef enum logic [1:0] {
        STATUS_TAKEN     = 2'd0,
        STATUS_FRAME_END = 2'd1,
        STATUS_IGNORED   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FILL,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic               cmd;
        logic [7:0]         byte_in;
        logic [RADDR_W-1:0] read_address;
    } in_t;

    typedef struct packed {
        status_t           status;
        logic [FCNT_W-1:0] frames_done;
        logic [7:0]        read_data;
        logic              write_dropped;
    } out_t;

    typedef struct packed {
        logic [POS_W-1:0]  frame_bytes;
        logic [FCNT_W-1:0] frame_total;
        logic [SPOS_W-1:0] stream_bytes;
    } cfg_t;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } mem_wr_t;

endpackage

`default_nettype wire

// File: rtl/drfd_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none

module drfd_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/drfd_cfg.sv
// configuration registers of the frame decoder
`default_nettype none

module drfd_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [drfd_pkg::CFG_IW-1:0]   wr_index,
    input  wire logic [drfd_pkg::CFG_DW-1:0]   wr_data,
    output drfd_pkg::cfg_t                     cfg
);

    drfd_pkg::cfg_t cfg_reg;
    drfd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                drfd_pkg::CFG_FRAME_BYTES:
                    cfg_next.frame_bytes  = wr_data[drfd_pkg::POS_W-1:0];
                drfd_pkg::CFG_FRAME_TOTAL:
                    cfg_next.frame_total  = wr_data[drfd_pkg::FCNT_W-1:0];
                drfd_pkg::CFG_STREAM_BYTES:
                    cfg_next.stream_bytes = wr_data[drfd_pkg::SPOS_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_bytes  <= 14'd4736;
            cfg_reg.frame_total  <= '0;
            cfg_reg.stream_bytes <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/drfd_ctrl.sv
// decode sequencer: command decode, fill loop, store clearing and read control
`default_nettype none

module drfd_ctrl (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire drfd_pkg::cfg_t                   cfg,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire drfd_pkg::in_t                    in_data,
    output logic                                  res_valid,
    input  wire logic                             res_taken,
    output drfd_pkg::out_t                        res_data,
    output drfd_pkg::mem_wr_t                     mem_wr,
    output logic                                  mem_rd_en,
    output logic      [drfd_pkg::STORE_AW-1:0]    mem_rd_addr,
    input  wire logic [7:0]                       mem_rd_data
);

    localparam int AW = drfd_pkg::STORE_AW;
    localparam logic [AW-1:0] CLR_LAST = AW'(drfd_pkg::MAX_FRAME_BYTES - 1);

    drfd_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                 clr_addr_reg, clr_addr_next;
    logic [drfd_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [drfd_pkg::LIT_W-1:0]    lit_reg, lit_next;
    logic [drfd_pkg::SPOS_W-1:0]   spos_reg, spos_next;
    logic [drfd_pkg::FCNT_W-1:0]   fcnt_reg, fcnt_next;
    logic                          open_reg, open_next;
    logic [drfd_pkg::LIT_W-1:0]    fill_left_reg, fill_left_next;
    logic                          fill_val_reg, fill_val_next;

    drfd_pkg::status_t             res_status_reg, res_status_next;
    logic [drfd_pkg::FCNT_W-1:0]   res_frames_reg, res_frames_next;
    logic [7:0]                    res_rdata_reg, res_rdata_next;
    logic                          res_drop_reg, res_drop_next;
    logic                          res_rdok_reg, res_rdok_next;

    logic                          accept;
    logic                          ignore;
    logic [drfd_pkg::POS_W-1:0]    eff_pos;
    logic [drfd_pkg::LIT_W-1:0]    eff_lit;
    logic [1:0]                    cmd_type;
    logic [drfd_pkg::LIT_W-1:0]    cmd_count;
    logic [drfd_pkg::FCNT_W-1:0]   fcnt_inc;
    logic [drfd_pkg::SPOS_W-1:0]   spos_inc;

    // saturating advance of the write position
    function automatic logic [drfd_pkg::POS_W-1:0] pos_add(
        input logic [drfd_pkg::POS_W-1:0] p,
        input logic [drfd_pkg::LIT_W-1:0] n
    );
        logic [drfd_pkg::POS_W:0] s;
        s = {1'b0, p} + (drfd_pkg::POS_W + 1)'(n);
        return s[drfd_pkg::POS_W] ? drfd_pkg::POS_MAX : s[drfd_pkg::POS_W-1:0];
    endfunction

    // write lands inside the frame and inside the store
    function automatic logic pos_ok(
        input logic [drfd_pkg::POS_W-1:0] p,
        input logic [drfd_pkg::POS_W-1:0] fb
    );
        return (p < fb) && (32'(p) < drfd_pkg::MAX_FRAME_BYTES);
    endfunction

    assign accept    = in_valid && !in_stall;
    assign eff_pos   = open_reg ? pos_reg : '0;
    assign eff_lit   = open_reg ? lit_reg : '0;
    assign ignore    = !open_reg && ((fcnt_reg >= cfg.frame_total) ||
                                     (spos_reg >= cfg.stream_bytes));
    assign cmd_type  = in_data.byte_in[7:6];
    assign cmd_count = in_data.byte_in[5:0];
    assign fcnt_inc  = (fcnt_reg != drfd_pkg::COUNT_MAX) ? fcnt_reg + 1'b1 : fcnt_reg;
    assign spos_inc  = (spos_reg != drfd_pkg::STREAM_MAX) ? spos_reg + 1'b1 : spos_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        pos_next        = pos_reg;
        lit_next        = lit_reg;
        spos_next       = spos_reg;
        fcnt_next       = fcnt_reg;
        open_next       = open_reg;
        fill_left_next  = fill_left_reg;
        fill_val_next   = fill_val_reg;
        res_status_next = res_status_reg;
        res_frames_next = res_frames_reg;
        res_rdata_next  = res_rdata_reg;
        res_drop_next   = res_drop_reg;
        res_rdok_next   = res_rdok_reg;

        in_stall    = (state_reg != drfd_pkg::ST_IDLE);
        res_valid   = 1'b0;
        mem_wr.we   = 1'b0;
        mem_wr.addr = '0;
        mem_wr.data = drfd_pkg::FILL_ZERO;
        mem_rd_en   = 1'b0;
        mem_rd_addr = AW'(in_data.read_address);

        unique case (state_reg)
            drfd_pkg::ST_CLEAR:
            begin
                // one store entry zeroed per cycle
                mem_wr.we   = 1'b1;
                mem_wr.addr = clr_addr_reg;
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next = drfd_pkg::ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            drfd_pkg::ST_IDLE:
            begin
                if (accept && (in_data.cmd == drfd_pkg::CMD_READ))
                begin
                    mem_rd_en       = 1'b1;
                    res_rdok_next   = (32'(in_data.read_address) <
                                       drfd_pkg::MAX_FRAME_BYTES);
                    res_status_next = drfd_pkg::STATUS_TAKEN;
                    res_frames_next = fcnt_reg;
                    res_drop_next   = 1'b0;
                    state_next      = drfd_pkg::ST_READ;
                end
                else if (accept)
                begin
                    res_rdata_next  = 8'h00;
                    res_drop_next   = 1'b0;
                    res_status_next = drfd_pkg::STATUS_TAKEN;
                    res_frames_next = fcnt_reg;
                    state_next      = drfd_pkg::ST_RESULT;
                    if (ignore)
                    begin
                        res_status_next = drfd_pkg::STATUS_IGNORED;
                    end
                    else
                    begin
                        open_next = 1'b1;
                        spos_next = spos_inc;
                        pos_next  = eff_pos;
                        lit_next  = eff_lit;
                        if (eff_lit != '0)
                        begin
                            // literal data byte, zero included
                            mem_wr.we     = pos_ok(eff_pos, cfg.frame_bytes);
                            mem_wr.addr   = AW'(eff_pos);
                            mem_wr.data   = in_data.byte_in;
                            res_drop_next = !pos_ok(eff_pos, cfg.frame_bytes);
                            pos_next      = pos_add(eff_pos, drfd_pkg::LIT_W'(1));
                            lit_next      = eff_lit - 1'b1;
                        end
                        else if (in_data.byte_in == drfd_pkg::END_BYTE)
                        begin
                            open_next       = 1'b0;
                            fcnt_next       = fcnt_inc;
                            res_frames_next = fcnt_inc;
                            res_status_next = drfd_pkg::STATUS_FRAME_END;
                        end
                        else
                        begin
                            unique case (cmd_type)
                                drfd_pkg::TYPE_SKIP:
                                    pos_next = pos_add(eff_pos, cmd_count);
                                drfd_pkg::TYPE_LIT:
                                    lit_next = cmd_count;
                                drfd_pkg::TYPE_FILL0, drfd_pkg::TYPE_FILL1:
                                begin
                                    fill_left_next = cmd_count;
                                    fill_val_next  = (cmd_type == drfd_pkg::TYPE_FILL1);
                                    if (cmd_count != '0)
                                    begin
                                        state_next = drfd_pkg::ST_FILL;
                                    end
                                end
                                default:
                                    pos_next = eff_pos;
                            endcase
                        end
                    end
                end
            end

            drfd_pkg::ST_READ:
            begin
                res_rdata_next = res_rdok_reg ? mem_rd_data : 8'h00;
                state_next     = drfd_pkg::ST_RESULT;
            end

            drfd_pkg::ST_FILL:
            begin
                mem_wr.we   = pos_ok(pos_reg, cfg.frame_bytes);
                mem_wr.addr = AW'(pos_reg);
                mem_wr.data = fill_val_reg ? drfd_pkg::FILL_ONE : drfd_pkg::FILL_ZERO;
                if (!pos_ok(pos_reg, cfg.frame_bytes))
                begin
                    res_drop_next = 1'b1;
                end
                pos_next       = pos_add(pos_reg, drfd_pkg::LIT_W'(1));
                fill_left_next = fill_left_reg - 1'b1;
                if (fill_left_reg == drfd_pkg::LIT_W'(1))
                begin
                    state_next = drfd_pkg::ST_RESULT;
                end
            end

            drfd_pkg::ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_taken)
                begin
                    state_next = drfd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = drfd_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drfd_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            pos_reg       <= '0;
            lit_reg       <= '0;
            spos_reg      <= '0;
            fcnt_reg      <= '0;
            open_reg      <= 1'b0;
            fill_left_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            pos_reg       <= pos_next;
            lit_reg       <= lit_next;
            spos_reg      <= spos_next;
            fcnt_reg      <= fcnt_next;
            open_reg      <= open_next;
            fill_left_reg <= fill_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_val_reg   <= fill_val_next;
        res_status_reg <= res_status_next;
        res_frames_reg <= res_frames_next;
        res_rdata_reg  <= res_rdata_next;
        res_drop_reg   <= res_drop_next;
        res_rdok_reg   <= res_rdok_next;
    end

    assign res_data.status        = res_status_reg;
    assign res_data.frames_done   = res_frames_reg;
    assign res_data.read_data     = res_rdata_reg;
    assign res_data.write_dropped = res_drop_reg;

endmodule

`default_nettype wire

// File: rtl/delta_rle_frame_decoder.sv
// top level of the delta run-length frame decoder
// the decoder takes no new item until the result of the last one has moved on; the fill loop writes
//   one frame store byte per cycle through the single write port of the ram
// reset: asynchronous, active low; afterwards the store is zeroed one entry a
//   cycle over all MAX_FRAME_BYTES entries, with in_stall high; config is taken
`default_nettype none

module delta_rle_frame_decoder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // stream and read items
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire drfd_pkg::in_t                   in_data,
    // result items
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output drfd_pkg::out_t                       out_data,
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [drfd_pkg::CFG_IW-1:0]     cfg_index,
    input  wire logic [drfd_pkg::CFG_DW-1:0]     cfg_data
);

    drfd_pkg::cfg_t    cfg;
    drfd_pkg::out_t    res_data;
    drfd_pkg::mem_wr_t mem_wr;
    logic              res_valid;
    logic              res_taken;
    logic              mem_rd_en;
    logic [drfd_pkg::STORE_AW-1:0] mem_rd_addr;
    logic [7:0]        mem_rd_data;

    // output register, parts the decoder from the consumer
    logic              out_valid_reg, out_valid_next;
    drfd_pkg::out_t    out_data_reg;

    // registers are always writable
    assign cfg_ready = 1'b1;

    drfd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    drfd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .res_valid   (res_valid),
        .res_taken   (res_taken),
        .res_data    (res_data),
        .mem_wr      (mem_wr),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // frame store, persists across frames
    drfd_ram #(
        .DEPTH (drfd_pkg::MAX_FRAME_BYTES),
        .AW    (drfd_pkg::STORE_AW),
        .DW    (8)
    ) u_store (
        .clk   (clk),
        .we    (mem_wr.we),
        .waddr (mem_wr.addr),
        .wdata (mem_wr.data),
        .re    (mem_rd_en),
        .raddr (mem_rd_addr),
        .rdata (mem_rd_data)
    );

    // a result moves in when the slot is empty or being drained this cycle
    assign res_taken = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_taken)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/drfd_checker.sv
// port-level checker of the frame decoder and its bind
`default_nettype none
`include "assert_macros.svh"

module drfd_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire drfd_pkg::out_t                  out_data
);

    // frame count of the last delivered result
    logic [drfd_pkg::FCNT_W-1:0] last_frames_reg;
    logic                        out_fire;
    logic                        out_wait;
    logic                        frame_end;
    logic                        ignored;
    logic                        count_stepped;
    logic                        count_kept;
    logic                        result_clean;

    assign out_fire  = out_valid && !out_stall;
    assign out_wait  = out_valid && out_stall;
    assign frame_end = (out_data.status == drfd_pkg::STATUS_FRAME_END);
    assign ignored   = (out_data.status == drfd_pkg::STATUS_IGNORED);

    // a frame end adds one, unless the count already sits at its top
    assign count_stepped = (out_data.frames_done == last_frames_reg + 1'b1) ||
                           (last_frames_reg == drfd_pkg::COUNT_MAX);
    assign count_kept    = (out_data.frames_done == last_frames_reg);
    assign result_clean  = !out_data.write_dropped && (out_data.read_data == 8'h00);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_frames_reg <= '0;
        end
        else if (out_fire)
        begin
            last_frames_reg <= out_data.frames_done;
        end
    end

    `DRFD_ASSERT(a_out_hold, out_wait |=> out_valid && $stable(out_data), "stalled result changed")

    `DRFD_ASSERT(a_frame_step, out_valid && frame_end |-> count_stepped, "frame end count step")

    `DRFD_ASSERT(a_count_kept, out_valid && !frame_end |-> count_kept, "count moved, no frame end")

    `DRFD_ASSERT(a_ignored_clean, out_valid && ignored |-> result_clean, "ignored byte not clean")

    `DRFD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result shown during reset")

endmodule

bind delta_rle_frame_decoder drfd_checker u_drfd_checker (.*);

`default_nettype wire
